>>> design/assert_macros.svh
// Shared assertion macros for the serializer design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, skipped while reset is held
`define TDSS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tdss assertion failed");

// Same, with a caller-supplied message
`define TDSS_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

>>> design/tdss_pkg.sv
package tdss_pkg;

    localparam int unsigned FRAME_BITS = 24;
    localparam int unsigned BIT_IDX_W  = 5;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT = 5'd23;

    // segment bit positions within one digit byte
    localparam logic [7:0] SEG_UL = 8'h01;
    localparam logic [7:0] SEG_TP = 8'h02;
    localparam logic [7:0] SEG_UR = 8'h04;
    localparam logic [7:0] SEG_LL = 8'h08;
    localparam logic [7:0] SEG_CT = 8'h10;
    localparam logic [7:0] SEG_LR = 8'h20;
    localparam logic [7:0] SEG_BT = 8'h40;

    // value / 1000 == (value * DIV1000_MUL) >> DIV1000_SHIFT, exact for 16-bit values
    localparam logic [16:0] DIV1000_MUL   = 17'd67109;
    localparam int unsigned DIV1000_SHIFT = 26;
    // n / 100 and n / 10 for n < 1000
    localparam logic [5:0]  DIV100_MUL    = 6'd41;
    localparam int unsigned DIV100_SHIFT  = 12;
    localparam logic [7:0]  DIV10_MUL     = 8'd205;
    localparam int unsigned DIV10_SHIFT   = 11;

    localparam logic [4:0] SWEEP_LEN = 5'd21;
    localparam logic [4:0] SWEEP_PER_DIGIT = 5'd7;

    typedef logic [FRAME_BITS-1:0] t_frame;

    typedef struct packed {
        logic        mode;
        logic [15:0] value;
        logic [4:0]  test_step;
    } t_in_req;

    typedef struct packed {
        logic                 data_bit;
        logic [BIT_IDX_W-1:0] bit_index;
        logic                 latch;
    } t_out_req;

    // read side of the frame queue as seen by the serializer
    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_q_rd;

    function automatic logic [7:0] glyph(input logic [3:0] digit);
        logic [7:0] g;
        case (digit)
            4'd0:    g = SEG_UL | SEG_TP | SEG_UR | SEG_LL | SEG_LR | SEG_BT;
            4'd1:    g = SEG_UR | SEG_LR;
            4'd2:    g = SEG_TP | SEG_UR | SEG_LL | SEG_CT | SEG_BT;
            4'd3:    g = SEG_TP | SEG_UR | SEG_CT | SEG_LR | SEG_BT;
            4'd4:    g = SEG_UL | SEG_UR | SEG_CT | SEG_LR;
            4'd5:    g = SEG_UL | SEG_TP | SEG_CT | SEG_LR | SEG_BT;
            4'd6:    g = SEG_UL | SEG_TP | SEG_LL | SEG_CT | SEG_LR | SEG_BT;
            4'd7:    g = SEG_TP | SEG_UR | SEG_LR;
            4'd8:    g = SEG_UL | SEG_TP | SEG_UR | SEG_LL | SEG_CT | SEG_LR | SEG_BT;
            4'd9:    g = SEG_UL | SEG_TP | SEG_UR | SEG_CT | SEG_LR | SEG_BT;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] sweep_seg(input logic [2:0] pos);
        logic [7:0] s;
        case (pos)
            3'd0:    s = SEG_UL;
            3'd1:    s = SEG_TP;
            3'd2:    s = SEG_UR;
            3'd3:    s = SEG_CT;
            3'd4:    s = SEG_LL;
            3'd5:    s = SEG_BT;
            3'd6:    s = SEG_LR;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // single lit segment; steps past the sweep give a blank frame
    function automatic t_frame test_frame(input logic [4:0] step);
        t_frame f;
        if (step < SWEEP_PER_DIGIT) begin
            f = {16'h0000, sweep_seg(step[2:0])};
        end else if (step < 2 * SWEEP_PER_DIGIT) begin
            f = {8'h00, sweep_seg(3'(step - SWEEP_PER_DIGIT)), 8'h00};
        end else if (step < SWEEP_LEN) begin
            f = {sweep_seg(3'(step - 2 * SWEEP_PER_DIGIT)), 16'h0000};
        end else begin
            f = '0;
        end
        return f;
    endfunction

endpackage

>>> design/tdss_front.sv
module tdss_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tdss_pkg::t_in_req i_in_req,
    output logic              o_full,
    input  logic              i_q_full,
    output logic              o_q_wr,
    output tdss_pkg::t_frame  o_q_frame
);

    logic        en;
    logic        r_v1, r_v2, r_v3;
    logic        n_v1, n_v2, n_v3;

    // stage 1: value / 1000
    logic        r1_mode;
    logic [4:0]  r1_step;
    logic [15:0] r1_value;
    logic [6:0]  r1_q;
    logic [32:0] div1000_prod;

    // stage 2: value mod 1000
    logic        r2_mode;
    logic [4:0]  r2_step;
    logic [9:0]  r2_n;
    logic [15:0] mod_full;

    // stage 3: hundreds and n / 10
    logic        r3_mode;
    logic [4:0]  r3_step;
    logic [9:0]  r3_n;
    logic [3:0]  r3_hund;
    logic [6:0]  r3_tdiv;
    logic [15:0] hund_prod;
    logic [17:0] tdiv_prod;

    logic [9:0]  ones_full;
    logic [6:0]  tens_full;
    logic [3:0]  ones, tens;
    tdss_pkg::t_frame num_frame;

    // pipeline advances unless the last stage holds an item the queue cannot take
    assign en     = !(r_v3 && i_q_full);
    assign o_full = !en;

    assign n_v1 = en ? i_push : r_v1;
    assign n_v2 = en ? r_v1   : r_v2;
    assign n_v3 = en ? r_v2   : r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    assign div1000_prod = {17'd0, i_in_req.value} * {16'd0, tdss_pkg::DIV1000_MUL};
    assign mod_full     = r1_value - 16'(r1_q) * 16'd1000;
    assign hund_prod    = {6'd0, r2_n} * {10'd0, tdss_pkg::DIV100_MUL};
    assign tdiv_prod    = {8'd0, r2_n} * {10'd0, tdss_pkg::DIV10_MUL};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mode  <= i_in_req.mode;
            r1_step  <= i_in_req.test_step;
            r1_value <= i_in_req.value;
            r1_q     <= div1000_prod[tdss_pkg::DIV1000_SHIFT +: 7];

            r2_mode  <= r1_mode;
            r2_step  <= r1_step;
            r2_n     <= mod_full[9:0];

            r3_mode  <= r2_mode;
            r3_step  <= r2_step;
            r3_n     <= r2_n;
            r3_hund  <= hund_prod[tdss_pkg::DIV100_SHIFT +: 4];
            r3_tdiv  <= tdiv_prod[tdss_pkg::DIV10_SHIFT +: 7];
        end
    end

    assign ones_full = r3_n - 10'(r3_tdiv) * 10'd10;
    assign tens_full = r3_tdiv - 7'(r3_hund) * 7'd10;
    assign ones      = ones_full[3:0];
    assign tens      = tens_full[3:0];

    // leading-zero blanking: tens shows when hundreds or tens is nonzero
    always_comb begin
        num_frame = {16'h0000, tdss_pkg::glyph(ones)};
        if (r3_hund != 4'd0 || tens != 4'd0) begin
            num_frame[15:8] = tdss_pkg::glyph(tens);
        end
        if (r3_hund != 4'd0) begin
            num_frame[23:16] = tdss_pkg::glyph(r3_hund);
        end
    end

    assign o_q_wr    = r_v3 && !i_q_full;
    assign o_q_frame = r3_mode ? tdss_pkg::test_frame(r3_step) : num_frame;

endmodule

>>> design/tdss_queue.sv
module tdss_queue #(
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr,
    input  tdss_pkg::t_frame         i_wr_frame,
    output logic                     o_full,
    input  logic                     i_rd,
    output tdss_pkg::t_q_rd          o_rd,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    tdss_pkg::t_frame r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_wr, do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && (r_count != '0);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_wr) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (do_rd) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr_frame;
        end
    end

    assign o_rd.valid = (r_count != '0);
    assign o_rd.frame = r_mem[r_rptr];
    assign o_count    = r_count;

endmodule

>>> design/tdss_back.sv
module tdss_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tdss_pkg::t_q_rd    i_q_rd,
    output logic               o_q_rd,
    input  logic               pop,
    output logic               empty,
    output tdss_pkg::t_out_req o_out_req
);

    logic                          r_busy, n_busy;
    logic [tdss_pkg::BIT_IDX_W-1:0] r_idx, n_idx;
    tdss_pkg::t_frame              r_shift, n_shift;
    logic                          at_last, load_slot;

    assign at_last   = (r_idx == tdss_pkg::LAST_BIT);
    // a new frame may enter when idle or as the last bit leaves
    assign load_slot = !r_busy || (pop && at_last);
    assign o_q_rd    = load_slot && i_q_rd.valid;

    always_comb begin
        n_busy  = r_busy;
        n_idx   = r_idx;
        n_shift = r_shift;
        if (load_slot) begin
            n_busy  = i_q_rd.valid;
            n_idx   = '0;
            n_shift = i_q_rd.frame;
        end else if (pop) begin
            n_idx   = r_idx + 1'b1;
            n_shift = {1'b0, r_shift[tdss_pkg::FRAME_BITS-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

    assign empty               = !r_busy;
    assign o_out_req.data_bit  = r_shift[0];
    assign o_out_req.bit_index = r_idx;
    assign o_out_req.latch     = at_last;

endmodule

>>> design/three_digit_seven_segment_serializer_top.sv
// Channel   Direction  Handshake          Payload
// request   in         push / full        i_in_req  (mode, value, test_step)
// result    out        pop / empty        o_out_req (data_bit, bit_index, latch)
//
// Each request yields 24 results, one per cycle while pop is held; frames run
// back to back, so the sustained request rate is set by the
// one-bit-per-cycle shift register in the back end.
// After a request is accepted, its first bit passes the 3-stage digit pipeline,
// the frame queue write and the shift register load before it is shown. Reset is
// synchronous; it empties the pipeline, queue and shifter. A stalled result
// side fills the queue and then asserts full.
`include "assert_macros.svh"

module three_digit_seven_segment_serializer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tdss_pkg::t_in_req  i_in_req,
    output logic               empty,
    input  logic               pop,
    output tdss_pkg::t_out_req o_out_req
);

    logic                           q_full;
    logic                           q_wr;
    tdss_pkg::t_frame               q_wr_frame;
    logic                           q_rd;
    tdss_pkg::t_q_rd                q_rd_data;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

    tdss_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_req  (i_in_req),
        .o_full    (full),
        .i_q_full  (q_full),
        .o_q_wr    (q_wr),
        .o_q_frame (q_wr_frame)
    );

    tdss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (q_wr),
        .i_wr_frame (q_wr_frame),
        .o_full     (q_full),
        .i_rd       (q_rd),
        .o_rd       (q_rd_data),
        .o_count    (q_count)
    );

    tdss_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_rd    (q_rd_data),
        .o_q_rd    (q_rd),
        .pop       (pop),
        .empty     (empty),
        .o_out_req (o_out_req)
    );

    // bits of one frame leave in order with no gap in the index
    `TDSS_ASSERT(a_bit_order, i_clk, i_rst_n,
        (pop && !empty && !o_out_req.latch) |=>
            (!empty && o_out_req.bit_index == $past(o_out_req.bit_index) + 1))

    // a frame always starts at bit 0
    `TDSS_ASSERT_MSG(a_frame_start, i_clk, i_rst_n,
        $rose(!empty) |-> (o_out_req.bit_index == '0), "frame did not start at bit 0")

    `TDSS_ASSERT_MSG(a_queue_bound, i_clk, i_rst_n,
        q_count <= QUEUE_DEPTH, "frame queue overflow")

endmodule

>>> tb/tdss_frame_checker.sv
`timescale 1ns / 100ps

module tdss_frame_checker
    import tdss_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  logic     i_full,
    input  t_in_req  i_in_req,
    input  logic     i_empty,
    input  logic     i_pop,
    input  t_out_req i_out_req,
    output int       o_fail_count,
    output int       o_pending
);

    t_out_req expected_bits[$];
    int       fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string msg);
        $display("%0t: result mismatch: %s", $time, msg);
        fail_total++;
    endtask

    function automatic logic [7:0] digit_segments(input int unsigned d);
        logic [7:0] s;
        case (d)
            0: s = SEG_UL | SEG_TP | SEG_UR | SEG_LL | SEG_LR | SEG_BT;
            1: s = SEG_UR | SEG_LR;
            2: s = SEG_TP | SEG_UR | SEG_LL | SEG_CT | SEG_BT;
            3: s = SEG_TP | SEG_UR | SEG_CT | SEG_LR | SEG_BT;
            4: s = SEG_UL | SEG_UR | SEG_CT | SEG_LR;
            5: s = SEG_UL | SEG_TP | SEG_CT | SEG_LR | SEG_BT;
            6: s = SEG_UL | SEG_TP | SEG_LL | SEG_CT | SEG_LR | SEG_BT;
            7: s = SEG_TP | SEG_UR | SEG_LR;
            8: s = SEG_UL | SEG_TP | SEG_UR | SEG_LL | SEG_CT | SEG_LR | SEG_BT;
            default: s = SEG_UL | SEG_TP | SEG_UR | SEG_CT | SEG_LR | SEG_BT;
        endcase
        return s;
    endfunction

    // lamp test walks UL, TP, UR, CT, LL, BT, LR on each digit in turn
    function automatic logic [7:0] sweep_segment(input int unsigned pos);
        logic [7:0] s;
        case (pos)
            0: s = SEG_UL;
            1: s = SEG_TP;
            2: s = SEG_UR;
            3: s = SEG_CT;
            4: s = SEG_LL;
            5: s = SEG_BT;
            default: s = SEG_LR;
        endcase
        return s;
    endfunction

    function automatic t_frame segment_frame(input t_in_req req);
        int unsigned n;
        int unsigned ones;
        int unsigned tens;
        int unsigned hund;
        int unsigned step;
        t_frame      f;
        f = '0;
        if (req.mode) begin
            step = req.test_step;
            if (step < SWEEP_LEN)
                f = t_frame'(sweep_segment(step % 7)) << (8 * (step / 7));
        end else begin
            n    = req.value % 1000;
            ones = n % 10;
            tens = (n / 10) % 10;
            hund = n / 100;
            f[7:0] = digit_segments(ones);
            // tens blanks only as a leading zero
            if (hund != 0 || tens != 0)
                f[15:8] = digit_segments(tens);
            if (hund != 0)
                f[23:16] = digit_segments(hund);
        end
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_frame   f;
        t_out_req want;
        if (!i_rst_n) begin
            expected_bits.delete();
        end else begin
            if (i_push && !i_full) begin
                f = segment_frame(i_in_req);
                for (int k = 0; k < FRAME_BITS; k++) begin
                    expected_bits.push_back('{data_bit: f[k],
                                              bit_index: k[BIT_IDX_W-1:0],
                                              latch: (k == FRAME_BITS - 1)});
                end
            end
            if (i_pop && !i_empty) begin
                if (expected_bits.size() == 0) begin
                    report_mismatch($sformatf("result popped with nothing expected (bit_index %0d)",
                                              i_out_req.bit_index));
                end else begin
                    want = expected_bits.pop_front();
                    if (i_out_req.data_bit !== want.data_bit)
                        report_mismatch($sformatf("data_bit got %0d, expected %0d",
                                                  i_out_req.data_bit, want.data_bit));
                    if (i_out_req.bit_index !== want.bit_index)
                        report_mismatch($sformatf("bit_index got %0d, expected %0d",
                                                  i_out_req.bit_index, want.bit_index));
                    if (i_out_req.latch !== want.latch)
                        report_mismatch($sformatf("latch got %0d, expected %0d",
                                                  i_out_req.latch, want.latch));
                end
            end
        end
        o_pending <= expected_bits.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import tdss_pkg::*;

    localparam logic MODE_NUMBER = 1'b0;
    localparam logic MODE_TEST   = 1'b1;
    localparam int   LONG_HOLD   = 300;

    logic     i_clk;
    logic     i_rst_n;
    logic     push;
    logic     full;
    logic     empty;
    logic     pop;
    t_in_req  in_req;
    t_out_req out_req;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int hold_trigger  = 0;

    three_digit_seven_segment_serializer_top dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_req  (in_req),
        .empty     (empty),
        .pop       (pop),
        .o_out_req (out_req)
    );

    tdss_frame_checker frame_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_req     (in_req),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_req    (out_req),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("** three_digit_seven_segment_serializer_top: FAILED **");
        $finish;
    end

    // result side: random stalls, plus a long hold-off whenever the trigger moves
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_trigger) begin
                hold_seen = hold_trigger;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= pop_stall_pct);
            end
        end
    end

    function automatic t_in_req number_req(input logic [15:0] v);
        t_in_req r;
        r.mode      = MODE_NUMBER;
        r.value     = v;
        r.test_step = 5'($urandom_range(0, 31));
        return r;
    endfunction

    function automatic t_in_req lamp_req(input logic [4:0] step);
        t_in_req r;
        r.mode      = MODE_TEST;
        r.value     = 16'($urandom);
        r.test_step = step;
        return r;
    endfunction

    function automatic t_in_req random_req();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return lamp_req(5'($urandom_range(0, 99) < 80 ? $urandom_range(0, 20)
                                                          : $urandom_range(21, 31)));
        else if (pick < 55)
            return number_req(16'($urandom));
        else if (pick < 75)
            return number_req(16'($urandom_range(0, 999)));
        else if (pick < 90)
            return number_req(16'($urandom_range(0, 99)));
        else
            return number_req(16'($urandom_range(0, 9)));
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance with push held
    task automatic offer_request(input t_in_req r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        in_req <= r;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int count, input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        pop_stall_pct = stall_pct;
        repeat (count) offer_request(random_req());
    endtask

    initial begin
        push    = 1'b0;
        in_req  = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // digit edges, leading-zero blanking and the lamp sweep ends
        offer_request(number_req(16'd0));
        offer_request(number_req(16'd7));
        offer_request(number_req(16'd8));
        offer_request(number_req(16'd9));
        offer_request(number_req(16'd10));
        offer_request(number_req(16'd99));
        offer_request(number_req(16'd100));
        offer_request(number_req(16'd905));
        offer_request(number_req(16'd999));
        offer_request(number_req(16'd1000));
        offer_request(number_req(16'd1234));
        offer_request(number_req(16'd65535));
        offer_request(number_req(16'd888));
        offer_request(number_req(16'd2056));
        offer_request(lamp_req(5'd0));
        offer_request(lamp_req(5'd6));
        offer_request(lamp_req(5'd7));
        offer_request(lamp_req(5'd13));
        offer_request(lamp_req(5'd14));
        offer_request(lamp_req(5'd20));
        offer_request(lamp_req(5'd21));
        offer_request(lamp_req(5'd31));

        run_phase(24, 0, 0);
        run_phase(24, 55, 0);
        run_phase(24, 0, 55);
        run_phase(24, 26, 26);

        // stall the result side long enough for full to come up
        hold_trigger = hold_trigger + 1;
        run_phase(12, 0, 0);

        push <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (fail_count == 0)
            $display("** three_digit_seven_segment_serializer_top: PASSED **");
        else
            $display("** three_digit_seven_segment_serializer_top: FAILED **");
        $finish;
    end

endmodule
